@@ hw/rtl/lss_pkg.sv @@
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the line sensor steering block
// Sensor weights, position bands, duty adjust codes and controller commands.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned NumSens  = 6;
  localparam int unsigned SampleW  = 10;
  localparam int unsigned WeightW  = 12;
  localparam int unsigned TotalW   = 13;   // sum of all weights is 6600
  localparam int unsigned CountW   = 3;
  localparam int unsigned PosW     = 14;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned BaseW    = 8;
  localparam int unsigned DiffW    = 6;
  localparam int unsigned RetryW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned StepW    = 4;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 32;

  localparam logic [StepW-1:0]  DivLast = StepW'(TotalW - 1);
  localparam logic [PosW-1:0]   PosAll  = 14'd10000;
  localparam logic [CountW-1:0] CntAll  = CountW'(NumSens);

  localparam logic [WeightW-1:0] SensWeight [NumSens] = '{
    12'd100, 12'd200, 12'd300, 12'd1000, 12'd2000, 12'd3000
  };

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBase      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDiff      = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRetry     = 2'd3;

  typedef enum logic [3:0] {
    BAND_NONE, BAND_CENTER, BAND_R1, BAND_R2, BAND_R3, BAND_R4,
    BAND_L1, BAND_L2, BAND_L3, BAND_L4
  } band_e;

  // duty adjust relative to base: +0, +d, +2d, +3d, +4d, -d/2, -d
  typedef enum logic [2:0] {
    ADJ_ZERO, ADJ_D1, ADJ_D2, ADJ_D3, ADJ_D4, ADJ_MH, ADJ_MD
  } adj_e;

  typedef enum logic [1:0] {
    KIND_TURN, KIND_PAUSE, KIND_STOP
  } kind_e;

  typedef struct packed {
    logic  load;
    logic  div_step;
    logic  fin;
    logic  out_load;
    kind_e out_kind;
  } lss_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [RetryW-1:0] retry;
  } lss_sts_t;

  function automatic band_e band_of(input logic [PosW-1:0] pos);
    band_e b;
    b = BAND_NONE;
    priority if (pos >= 14'd1400 && pos < 14'd1500) b = BAND_CENTER;
    else if (pos >= 14'd1500 && pos < 14'd1600)     b = BAND_R1;
    else if (pos > 14'd1700 && pos < 14'd2200)      b = BAND_R2;
    else if (pos > 14'd2200 && pos < 14'd2700)      b = BAND_R3;
    else if (pos > 14'd2700 && pos < 14'd3200)      b = BAND_R4;
    else if (pos > 14'd590 && pos < 14'd700)        b = BAND_L1;
    else if (pos > 14'd200 && pos < 14'd300)        b = BAND_L2;
    else if (pos > 14'd120 && pos < 14'd170)        b = BAND_L3;
    else if (pos > 14'd90 && pos < 14'd110)         b = BAND_L4;
    else                                            b = BAND_NONE;
    return b;
  endfunction

  function automatic adj_e left_adj(input band_e b);
    adj_e a;
    unique case (b)
      BAND_R1: a = ADJ_D1;
      BAND_R2: a = ADJ_D2;
      BAND_R3: a = ADJ_D3;
      BAND_R4: a = ADJ_D4;
      BAND_L3: a = ADJ_MH;
      BAND_L4: a = ADJ_MD;
      default: a = ADJ_ZERO;
    endcase
    return a;
  endfunction

  function automatic adj_e right_adj(input band_e b);
    adj_e a;
    unique case (b)
      BAND_L1: a = ADJ_D1;
      BAND_L2: a = ADJ_D2;
      BAND_L3: a = ADJ_D3;
      BAND_L4: a = ADJ_D4;
      BAND_R3: a = ADJ_MH;
      BAND_R4: a = ADJ_MD;
      default: a = ADJ_ZERO;
    endcase
    return a;
  endfunction

  // base plus adjust, clamped to 0..255; range is -63..507 in 10 bits
  function automatic logic [DutyW-1:0] apply_adj(input logic [BaseW-1:0] b,
                                                 input logic [DiffW-1:0] d,
                                                 input adj_e a);
    logic [9:0] s;
    logic [DutyW-1:0] r;
    unique case (a)
      ADJ_D1:  s = {2'b00, b} + {4'b0000, d};
      ADJ_D2:  s = {2'b00, b} + {3'b000, d, 1'b0};
      ADJ_D3:  s = {2'b00, b} + {4'b0000, d} + {3'b000, d, 1'b0};
      ADJ_D4:  s = {2'b00, b} + {2'b00, d, 2'b00};
      ADJ_MH:  s = {2'b00, b} - {5'b00000, d[DiffW-1:1]};
      ADJ_MD:  s = {2'b00, b} - {4'b0000, d};
      default: s = {2'b00, b};
    endcase
    if (s[9])      r = '0;
    else if (s[8]) r = '1;
    else           r = s[7:0];
    return r;
  endfunction

endpackage

@@ hw/rtl/lss_dp.sv @@
// ----------------------------------------------------------------------------
// lss_dp: steering datapath
// Config registers, sensor sum, bit-serial divider, band decode, result regs.
// ----------------------------------------------------------------------------
module lss_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lss_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [lss_pkg::InDataW-1:0]   in_data_i,
  input  lss_pkg::lss_cmd_t             cmd_i,
  output lss_pkg::lss_sts_t             sts_o,
  output logic [lss_pkg::OutDataW-1:0]  out_data_o,
  output logic                          out_pause_o,
  output logic                          out_last_o
);
  import lss_pkg::*;

  logic [SampleW-1:0] thr_q;
  logic [BaseW-1:0]   base_q;
  logic [DiffW-1:0]   diff_q;
  logic [RetryW-1:0]  retry_q;

  logic [TotalW-1:0]  dvd_q;     // dividend, quotient shifts in from the bottom
  logic [CountW-1:0]  rem_q;
  logic [CountW-1:0]  cnt_q;
  logic [PosW-1:0]    pos_q;
  band_e              band_q;
  logic [DutyW-1:0]   left_q, right_q;
  logic               pause_q, last_q;

  logic [TotalW-1:0]  total_d;
  logic [CountW-1:0]  count_d;
  logic [CountW:0]    trial;
  logic [PosW-1:0]    pos_d;

  always_comb begin
    total_d = '0;
    count_d = '0;
    for (int i = 0; i < NumSens; i++) begin
      if (in_data_i[i*SampleW +: SampleW] < thr_q) begin
        total_d = total_d + TotalW'(SensWeight[i]);
        count_d = count_d + 1'b1;
      end
    end
  end

  assign trial = {rem_q, dvd_q[TotalW-1]};

  always_comb begin
    if (cnt_q == '0)         pos_d = '0;
    else if (cnt_q == CntAll) pos_d = PosAll;
    else                     pos_d = PosW'(dvd_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      base_q  <= 8'd125;
      diff_q  <= 6'd20;
      retry_q <= 3'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgThreshold: thr_q   <= cfg_data_i;
        CfgBase:      base_q  <= cfg_data_i[BaseW-1:0];
        CfgDiff:      diff_q  <= cfg_data_i[DiffW-1:0];
        CfgRetry:     retry_q <= cfg_data_i[RetryW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dvd_q <= total_d;
      rem_q <= '0;
      cnt_q <= count_d;
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, cnt_q}) begin
        rem_q <= CountW'(trial - {1'b0, cnt_q});
        dvd_q <= {dvd_q[TotalW-2:0], 1'b1};
      end else begin
        rem_q <= trial[CountW-1:0];
        dvd_q <= {dvd_q[TotalW-2:0], 1'b0};
      end
    end
    if (cmd_i.fin) begin
      pos_q  <= pos_d;
      band_q <= band_of(pos_d);
    end
    if (cmd_i.out_load) begin
      unique case (cmd_i.out_kind)
        KIND_TURN: begin
          left_q  <= apply_adj(base_q, diff_q, left_adj(band_q));
          right_q <= apply_adj(base_q, diff_q, right_adj(band_q));
          pause_q <= 1'b0;
          last_q  <= 1'b1;
        end
        KIND_PAUSE: begin
          left_q  <= base_q;
          right_q <= base_q;
          pause_q <= 1'b1;
          last_q  <= 1'b0;
        end
        default: begin
          left_q  <= '0;
          right_q <= '0;
          pause_q <= 1'b0;
          last_q  <= 1'b1;
        end
      endcase
    end
  end

  assign sts_o.hit   = (band_q != BAND_NONE);
  assign sts_o.retry = retry_q;

  assign out_data_o  = {2'b00, pos_q, right_q, left_q};
  assign out_pause_o = pause_q;
  assign out_last_o  = last_q;

endmodule

@@ hw/rtl/lss_ctrl.sv @@
// ----------------------------------------------------------------------------
// lss_ctrl: steering controller
// Sequences accept, divide, band decode and the run of result transfers.
// ----------------------------------------------------------------------------
module lss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  lss_pkg::lss_sts_t  sts_i,
  output lss_pkg::lss_cmd_t  cmd_o
);
  import lss_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_FIN, ST_LOAD, ST_OUT} state_e;

  state_e            state_q;
  logic [StepW-1:0]  step_q;
  logic [RetryW-1:0] pcnt_q;
  kind_e             kind_q;
  logic              tracked_q;
  logic              out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_kind = KIND_STOP;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.fin      = (state_q == ST_FIN);
    if (state_q == ST_LOAD) begin
      cmd_o.out_load = 1'b1;
      if (sts_i.hit)      cmd_o.out_kind = KIND_TURN;
      else if (tracked_q) cmd_o.out_kind = KIND_PAUSE;
      else                cmd_o.out_kind = KIND_STOP;
    end else if (state_q == ST_OUT && out_ready_i && kind_q == KIND_PAUSE) begin
      cmd_o.out_load = 1'b1;
      cmd_o.out_kind = (pcnt_q != '0) ? KIND_PAUSE : KIND_STOP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      pcnt_q      <= '0;
      kind_q      <= KIND_STOP;
      tracked_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DIV;
            step_q  <= DivLast;
          end
        end
        ST_DIV: begin
          if (step_q == '0) state_q <= ST_FIN;
          else              step_q  <= step_q - 1'b1;
        end
        ST_FIN: state_q <= ST_LOAD;
        ST_LOAD: begin
          state_q     <= ST_OUT;
          out_valid_q <= 1'b1;
          kind_q      <= cmd_o.out_kind;
          tracked_q   <= sts_i.hit;
          pcnt_q      <= sts_i.retry;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            if (kind_q == KIND_PAUSE) begin
              kind_q <= cmd_o.out_kind;
              if (pcnt_q != '0) pcnt_q <= pcnt_q - 1'b1;
            end else begin
              out_valid_q <= 1'b0;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_valid_only_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> state_q == ST_OUT)
    else $error("result valid outside output state");

  a_turn_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && kind_q == KIND_TURN) |=> !out_valid_q)
    else $error("turn result did not end the run");

  a_pause_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && kind_q == KIND_PAUSE) |=> out_valid_q)
    else $error("run ended on a pause result");

  a_tracked_follows_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> (tracked_q == $past(sts_i.hit)))
    else $error("tracking flag does not follow band match");
`endif

endmodule

@@ hw/rtl/line_sensor_steering.sv @@
// ----------------------------------------------------------------------------
// line_sensor_steering: weighted-position line follower steering
// Six reflectance samples in, one run of left/right motor duties out.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: sample_0..sample_5
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: left, right, position;
//                                                tuser: pause; tlast: last
//  cfg       in   cfg_we_i (no back-pressure)    cfg_index_i, cfg_data_i
//
//  Steps: accept, 13 divider steps (one quotient bit per cycle), position and
//  band decode, result load, then the first result is valid; a one-result scan
//  is ready to accept again once its result is transferred.
//  Further results of a lost-line run are valid the cycle after each transfer.
//  One scan in flight at a time (s_axis_tready only when idle); a stalled
//  result holds its payload. Reset restores register defaults, clears tracking.
//
// Position = sum of weights of sensors below threshold / their count, with
// 0 for none and 10000 for all six. Nine bands map position to duties; a
// position in no band stops the motors, preceded by retry_count+1 straight
// pulses flagged pause when the previous scan was on a band.
module line_sensor_steering (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [lss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lss_pkg::CfgDataW-1:0]  cfg_data_i,
  // sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lss_pkg::InDataW-1:0]   s_axis_tdata,  // sample_0..sample_5, 10b each
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lss_pkg::OutDataW-1:0]  m_axis_tdata,  // left_duty, right_duty, line_position
  output logic                          m_axis_tuser,  // pause_after
  output logic                          m_axis_tlast   // last_of_run
);
  import lss_pkg::*;

  lss_cmd_t cmd;
  lss_sts_t sts;

  lss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata),
    .out_pause_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
